### rtl/fnpp_pkg.sv
package fnpp_pkg;

  localparam logic [33:0] MHZ = 34'd1000000;
  localparam logic [33:0] FREQ_MIN = 34'd20000000;
  localparam logic [33:0] FREQ_MAX = 34'd9800000000;
  localparam logic [33:0] FREQ_DBL = 34'd7100000000;
  localparam logic [33:0] FREQ_CHDIV = 34'd3550000000;
  localparam logic [41:0] VCO2_MIN = 42'd7100000000;
  localparam logic [41:0] VCO2_MAX = 42'd14200000000;
  localparam logic [41:0] VCO2_VTUNE = 42'd13000000000;
  localparam logic [31:0] FRAC_FULL = 32'hFFFF_FFFF;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_OUT_RANGE = 2'd1;
  localparam logic [1:0] STAT_VCO_RANGE = 2'd2;
  localparam logic [1:0] STAT_N_LOW = 2'd3;

  localparam logic CFG_PFD = 1'b0;
  localparam logic CFG_MASH = 1'b1;

  // channel divider steps: lower bound in MHz, total ratio, seg1 /3, seg2 and seg3 ratio
  localparam logic [10:0] CHDIV_LOW [15] = '{11'd1775, 11'd1184, 11'd888, 11'd592, 11'd444,
    11'd296, 11'd222, 11'd148, 11'd111, 11'd99, 11'd74, 11'd56, 11'd37, 11'd28, 11'd20};
  localparam logic [7:0] CHDIV_RATIO [15] = '{8'd2, 8'd3, 8'd4, 8'd6, 8'd8, 8'd12, 8'd16,
    8'd24, 8'd32, 8'd36, 8'd48, 8'd64, 8'd96, 8'd128, 8'd192};
  localparam logic CHDIV_DIV3 [15] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
    1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam logic [3:0] CHDIV_R2 [15] = '{4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd6, 4'd8, 4'd8,
    4'd8, 4'd6, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8};
  localparam logic [3:0] CHDIV_R3 [15] = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd2, 4'd2, 4'd2, 4'd4, 4'd6, 4'd8, 4'd8};

  typedef struct packed {
    logic [7:0] total;
    logic       div3;
    logic [3:0] r2;
    logic [3:0] r3;
  } chdiv_t;

  // request to the shared divider; dividend is left-aligned, count bits consumed
  typedef struct packed {
    logic        start;
    logic [67:0] dividend;
    logic [34:0] divisor;
    logic [6:0]  count;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [33:0] quo;
    logic [34:0] rem;
  } div_rsp_t;

  // first step whose bound the frequency reaches; last step otherwise
  function automatic chdiv_t chdiv_pick(input logic [33:0] f);
    chdiv_t s;
    s = '{CHDIV_RATIO[14], CHDIV_DIV3[14], CHDIV_R2[14], CHDIV_R3[14]};
    for (int k = 13; k >= 0; k--) begin
      if (f >= 34'(CHDIV_LOW[k]) * MHZ) begin
        s = '{CHDIV_RATIO[k], CHDIV_DIV3[k], CHDIV_R2[k], CHDIV_R3[k]};
      end
    end
    return s;
  endfunction

  function automatic logic [4:0] min_n(input logic [2:0] order);
    logic [4:0] n;
    case (order)
      3'd0: n = 5'd9;
      3'd1: n = 5'd11;
      3'd2: n = 5'd16;
      3'd3: n = 5'd18;
      3'd4: n = 5'd30;
      default: n = 5'd18;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] seg_code(input logic [3:0] ratio);
    logic [3:0] c;
    case (ratio)
      4'd2: c = 4'd1;
      4'd4: c = 4'd2;
      4'd6: c = 4'd4;
      4'd8: c = 4'd8;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

### rtl/fractional_n_pll_frequency_planner.sv
// One request at a time: s_tready is high only in ST_IDLE, and the next request is taken
// the cycle after the result word is loaded, which waits while an old word is unaccepted.
// A rejected request skips the bit-serial divider, an integer plan uses it once, and a
// fractional plan also uses it to round, for each Euclid step and twice to reduce.
// Reset (rst, synchronous, active high) idles the sequencer, drops m_tvalid and restores
// pfd_hz = 100 MHz and mod_order = 3.
module fractional_n_pll_frequency_planner (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // freq_hz[33:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, pll_n, frac_num, frac_den, vco_doubler, vt_adj, chdiv_enable,
  // seg_enables, seg1_div3, seg2_code, seg3_code, seg_select
  output logic [103:0] m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [29:0]  cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_DIVN   = 7'b0000100,
    ST_ROUND  = 7'b0001000,
    ST_GCD    = 7'b0010000,
    ST_REDUCE = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state;
  logic [29:0] pfd_hz;
  logic [2:0]  mod_order;

  logic        oor;
  logic        dbl;
  logic        chen;
  logic [2:0]  segen;
  logic        s1d3;
  logic [3:0]  c2;
  logic [3:0]  c3;
  logic [2:0]  sel;
  logic [41:0] vco2;
  logic [33:0] d;
  logic [1:0]  status;
  logic [11:0] pll_n;
  logic [33:0] rem;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] num;
  logic [31:0] den;
  logic        div_pend;
  logic        phase;

  fnpp_pkg::div_req_t req;
  fnpp_pkg::div_rsp_t rsp;

  logic [33:0]          f_in;
  fnpp_pkg::chdiv_t     step;
  logic [29:0]          pfd;
  logic [33:0]          d_calc;
  logic [38:0]          nd;
  logic [67:0]          xround;

  fnpp_div u_div (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign s_tready = (state == ST_IDLE);
  assign f_in = s_tdata[33:0];
  assign step = fnpp_pkg::chdiv_pick(f_in);
  assign pfd = (pfd_hz == '0) ? 30'd1 : pfd_hz;
  assign d_calc = dbl ? {1'b0, pfd, 3'b0} : {2'b0, pfd, 2'b0};
  assign nd = 39'(fnpp_pkg::min_n(mod_order)) * 39'(d_calc);
  // 2*rem*(2^32-1) + d
  assign xround = 68'({rem, 33'b0}) - 68'({rem, 1'b0}) + 68'(d);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pfd_hz    <= 30'd100000000;
      mod_order <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        fnpp_pkg::CFG_PFD:  pfd_hz <= cfg_data;
        fnpp_pkg::CFG_MASH: mod_order <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // divider launches
  always_comb begin
    req = '0;
    if (!div_pend && !rsp.busy) begin
      case (state)
        ST_DIVN: begin
          req = '{1'b1, {vco2[33:0], 34'b0}, {1'b0, d}, 7'd34};
        end
        ST_ROUND: begin
          req = '{1'b1, xround, {d, 1'b0}, 7'd68};
        end
        ST_GCD: begin
          if (b != '0) req = '{1'b1, {a, 36'b0}, {3'b0, b}, 7'd32};
        end
        ST_REDUCE: begin
          req = '{1'b1, {(phase ? fnpp_pkg::FRAC_FULL : num), 36'b0}, {3'b0, a}, 7'd32};
        end
        default: req = '0;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      div_pend <= 1'b0;
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      // a word loaded in ST_DONE keeps valid high
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      if (req.start) div_pend <= 1'b1;
      else if (rsp.done) div_pend <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (oor || vco2 < fnpp_pkg::VCO2_MIN || vco2 > fnpp_pkg::VCO2_MAX
              || vco2 < {3'b0, nd}) begin
            state <= ST_DONE;
          end else begin
            state <= ST_DIVN;
          end
        end
        ST_DIVN: begin
          if (rsp.done) state <= (rsp.rem == '0) ? ST_DONE : ST_ROUND;
        end
        ST_ROUND: begin
          if (rsp.done) state <= ST_GCD;
        end
        ST_GCD: begin
          if (!div_pend && !rsp.busy && b == '0) begin
            state <= ST_REDUCE;
            phase <= 1'b0;
          end
        end
        ST_REDUCE: begin
          if (rsp.done) begin
            phase <= 1'b1;
            if (phase) state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        oor  <= (f_in < fnpp_pkg::FREQ_MIN) || (f_in > fnpp_pkg::FREQ_MAX);
        dbl  <= f_in > fnpp_pkg::FREQ_DBL;
        chen <= f_in < fnpp_pkg::FREQ_CHDIV;
        s1d3 <= step.div3;
        c2   <= fnpp_pkg::seg_code(step.r2);
        c3   <= fnpp_pkg::seg_code(step.r3);
        segen <= {step.r3 != '0, step.r2 != '0, 1'b1};
        sel  <= (step.r3 != '0) ? 3'd4 : ((step.r2 != '0) ? 3'd2 : 3'd1);
        if (f_in > fnpp_pkg::FREQ_DBL) vco2 <= 42'(f_in);
        else if (f_in < fnpp_pkg::FREQ_CHDIV) vco2 <= 42'(f_in) * 42'({step.total, 1'b0});
        else vco2 <= 42'({f_in, 1'b0});
        num <= '0;
        den <= 32'd1;
        pll_n <= '0;
      end
      ST_CHECK: begin
        d <= d_calc;
        if (oor) status <= fnpp_pkg::STAT_OUT_RANGE;
        else if (vco2 < fnpp_pkg::VCO2_MIN || vco2 > fnpp_pkg::VCO2_MAX)
          status <= fnpp_pkg::STAT_VCO_RANGE;
        else if (vco2 < {3'b0, nd}) status <= fnpp_pkg::STAT_N_LOW;
        else status <= fnpp_pkg::STAT_OK;
      end
      ST_DIVN: begin
        if (rsp.done) begin
          pll_n <= rsp.quo[11:0];
          rem   <= rsp.rem[33:0];
        end
      end
      ST_ROUND: begin
        if (rsp.done) begin
          num <= rsp.quo[31:0];
          a   <= rsp.quo[31:0];
          b   <= fnpp_pkg::FRAC_FULL;
        end
      end
      ST_GCD: begin
        if (rsp.done) begin
          a <= b;
          b <= rsp.rem[31:0];
        end
      end
      ST_REDUCE: begin
        if (rsp.done) begin
          if (phase) den <= rsp.quo[31:0];
          else num <= rsp.quo[31:0];
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          if (status != fnpp_pkg::STAT_OK) begin
            m_tdata <= {7'b0, 3'b0, 4'b0, 4'b0, 1'b0, 3'b0, 1'b0, 2'b0, 1'b0,
                        32'd1, 32'd0, 12'd0, status};
          end else begin
            m_tdata <= {7'b0, (chen ? sel : 3'b0), (chen ? c3 : 4'b0), (chen ? c2 : 4'b0),
                        (chen & s1d3), (chen ? segen : 3'b0), chen,
                        ((vco2 >= fnpp_pkg::VCO2_VTUNE) ? 2'd3 : 2'd0), dbl,
                        den, num, pll_n, status};
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[77:46] != '0) else $error("zero denominator");
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != fnpp_pkg::STAT_OK) |-> (m_tdata[77:46] == 32'd1
      && m_tdata[45:2] == '0)) else $error("error result carries data");
  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !rsp.busy) else $error("divider restarted while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("accepted while working");
`endif

endmodule

### rtl/fnpp_div.sv
module fnpp_div (
  input  logic               clk,
  input  logic               rst,
  input  fnpp_pkg::div_req_t req,
  output fnpp_pkg::div_rsp_t rsp
);

  logic [67:0] dvd;
  logic [34:0] dvs;
  logic [34:0] r;
  logic [33:0] q;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [35:0] trial;
  logic        ge;
  logic [34:0] r_next;

  // one restoring step per cycle
  assign trial = {r, dvd[67]};
  assign ge = trial >= {1'b0, dvs};
  assign r_next = ge ? 35'(trial - {1'b0, dvs}) : trial[34:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      r   <= '0;
      q   <= '0;
      cnt <= req.count;
    end else if (busy) begin
      dvd <= {dvd[66:0], 1'b0};
      r   <= r_next;
      q   <= {q[32:0], ge};
      cnt <= cnt - 7'd1;
    end
  end

  assign rsp = '{busy, done, q, r};

endmodule

### verif/fractional_n_pll_frequency_planner_test.sv
`timescale 1ns / 100ps

module fractional_n_pll_frequency_planner_test;

  // one plan, in result-word field order
  typedef struct {
    logic [1:0]  status;
    logic [11:0] pll_n;
    logic [31:0] frac_num;
    logic [31:0] frac_den;
    logic        vco_doubler;
    logic [1:0]  vt_adj;
    logic        chdiv_enable;
    logic [2:0]  seg_enables;
    logic        seg1_div3;
    logic [3:0]  seg2_code;
    logic [3:0]  seg3_code;
    logic [2:0]  seg_select;
  } plan_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [39:0]  s_tdata;   // freq_hz[33:0]
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;   // status, pll_n, frac_num, frac_den, vco_doubler, vt_adj, ...
  logic         cfg_we;
  logic         cfg_index;
  logic [29:0]  cfg_data;

  // planner copy of the registers
  logic [29:0] pfd_cur;
  logic [2:0]  order_cur;

  plan_t plans_pending[$];
  int    fails;
  int    send_idle_pct;
  int    stall_pct;

  // channel divider steps
  int unsigned step_low_mhz[15] = '{1775, 1184, 888, 592, 444, 296, 222, 148, 111, 99, 74,
    56, 37, 28, 20};
  int unsigned step_total[15] = '{2, 3, 4, 6, 8, 12, 16, 24, 32, 36, 48, 64, 96, 128, 192};
  bit          step_div3[15] = '{0, 1, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0, 0, 0, 1};
  int unsigned step_r2[15] = '{0, 0, 2, 2, 4, 6, 8, 8, 8, 6, 8, 8, 8, 8, 8};
  int unsigned step_r3[15] = '{0, 0, 0, 0, 0, 0, 0, 0, 2, 2, 2, 4, 6, 8, 8};

  fractional_n_pll_frequency_planner i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [3:0] ratio_code(int unsigned r);
    case (r)
      2: return 4'd1;
      4: return 4'd2;
      6: return 4'd4;
      8: return 4'd8;
      default: return 4'd0;
    endcase
  endfunction

  // divider plan for one requested frequency
  function automatic plan_t plan_freq(logic [33:0] f);
    plan_t p;
    logic [41:0] vco2;
    logic [41:0] d;
    logic [41:0] pfd;
    logic [41:0] nmin;
    logic [41:0] rem;
    logic [127:0] wide;
    logic [31:0] a, b, t;
    int k;
    p = '{default: '0};
    p.frac_den = 32'd1;
    if (f < 34'd20_000_000 || f > 34'd9_800_000_000) begin
      p.status = fnpp_pkg::STAT_OUT_RANGE;
      return p;
    end
    if (f > 34'd7_100_000_000) begin
      p.vco_doubler = 1'b1;
      vco2 = 42'(f);
    end else if (f < 34'd3_550_000_000) begin
      k = 14;
      for (int i = 14; i >= 0; i--)
        if (42'(f) >= 42'(step_low_mhz[i]) * 42'd1_000_000) k = i;
      p.chdiv_enable = 1'b1;
      p.seg1_div3 = step_div3[k];
      p.seg_enables = 3'd1;
      p.seg_select = 3'd1;
      if (step_r2[k] != 0) begin
        p.seg_enables[1] = 1'b1;
        p.seg_select = 3'd2;
        p.seg2_code = ratio_code(step_r2[k]);
      end
      if (step_r3[k] != 0) begin
        p.seg_enables[2] = 1'b1;
        p.seg_select = 3'd4;
        p.seg3_code = ratio_code(step_r3[k]);
      end
      vco2 = 42'd2 * 42'(f) * 42'(step_total[k]);
    end else begin
      vco2 = 42'd2 * 42'(f);
    end
    if (vco2 < 42'd7_100_000_000 || vco2 > 42'd14_200_000_000) begin
      p = '{default: '0};
      p.frac_den = 32'd1;
      p.status = fnpp_pkg::STAT_VCO_RANGE;
      return p;
    end
    pfd = (pfd_cur == 0) ? 42'd1 : 42'(pfd_cur);
    nmin = (order_cur == 0) ? 42'd9 : (order_cur == 1) ? 42'd11 : (order_cur == 2) ? 42'd16 :
           (order_cur == 4) ? 42'd30 : 42'd18;
    d = 42'd2 * pfd * (p.vco_doubler ? 42'd4 : 42'd2);
    if (vco2 < nmin * d) begin
      p = '{default: '0};
      p.frac_den = 32'd1;
      p.status = fnpp_pkg::STAT_N_LOW;
      return p;
    end
    p.status = fnpp_pkg::STAT_OK;
    p.pll_n = 12'(vco2 / d);
    rem = vco2 % d;
    if (rem != 0) begin
      wide = (128'(rem) * 128'd2 * 128'h0_FFFF_FFFF + 128'(d)) / (128'(d) * 128'd2);
      a = wide[31:0];
      b = 32'hFFFF_FFFF;
      while (b != 0) begin
        t = b;
        b = a % b;
        a = t;
      end
      p.frac_num = wide[31:0] / a;
      p.frac_den = 32'hFFFF_FFFF / a;
    end
    p.vt_adj = (vco2 >= 42'd13_000_000_000) ? 2'd3 : 2'd0;
    return p;
  endfunction

  task automatic field_chk(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  // receiver: random stall, check each word against the oldest plan
  always @(posedge clk) begin
    plan_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
      if (m_tvalid && m_tready) begin
        if (plans_pending.size() == 0) begin
          $error("result word with no plan pending");
          fails++;
        end else begin
          e = plans_pending.pop_front();
          field_chk("status", 32'(e.status), 32'(m_tdata[1:0]));
          field_chk("pll_n", 32'(e.pll_n), 32'(m_tdata[13:2]));
          field_chk("frac_num", e.frac_num, m_tdata[45:14]);
          field_chk("frac_den", e.frac_den, m_tdata[77:46]);
          field_chk("vco_doubler", 32'(e.vco_doubler), 32'(m_tdata[78]));
          field_chk("vt_adj", 32'(e.vt_adj), 32'(m_tdata[80:79]));
          field_chk("chdiv_enable", 32'(e.chdiv_enable), 32'(m_tdata[81]));
          field_chk("seg_enables", 32'(e.seg_enables), 32'(m_tdata[84:82]));
          field_chk("seg1_div3", 32'(e.seg1_div3), 32'(m_tdata[85]));
          field_chk("seg2_code", 32'(e.seg2_code), 32'(m_tdata[89:86]));
          field_chk("seg3_code", 32'(e.seg3_code), 32'(m_tdata[93:90]));
          field_chk("seg_select", 32'(e.seg_select), 32'(m_tdata[96:94]));
        end
      end
    end
  end

  // one request word; valid stays high into the next call unless an idle gap falls
  task automatic send_freq(logic [33:0] f);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, f};
    do @(posedge clk); while (!s_tready);
    plans_pending.push_back(plan_freq(f));
  endtask

  // stop sending and wait for every plan to come back
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (plans_pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [29:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fnpp_pkg::CFG_PFD) pfd_cur = val;
    else order_cur = val[2:0];
  endtask

  function automatic logic [33:0] rand_range(logic [33:0] lo, logic [33:0] hi);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return lo + 34'(r % (64'(hi) - 64'(lo) + 64'd1));
  endfunction

  function automatic logic [33:0] rand_freq;
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(99);
    k = $urandom_range(14);
    if (pick < 60) return rand_range(34'd20_000_000, 34'd9_800_000_000);
    if (pick < 75) return 34'(step_low_mhz[k]) * 34'd1_000_000 - 34'd2 + 34'($urandom_range(4));
    if (pick < 88) return 34'($urandom_range(20, 9800)) * 34'd1_000_000;
    return 34'({$urandom, $urandom});
  endfunction

  // range edges, path switch points and integer mode
  task automatic run_edges;
    logic [33:0] edges[$] = '{34'd0, 34'h3_FFFF_FFFF, 34'd19_999_999, 34'd20_000_000,
      34'd9_800_000_000, 34'd9_800_000_001, 34'd7_100_000_000, 34'd7_100_000_001,
      34'd3_550_000_000, 34'd3_549_999_999, 34'd1_775_000_000, 34'd1_774_999_999,
      34'd5_000_000_000, 34'd3_600_000_000, 34'd3_550_000_001, 34'd8_000_000_007,
      34'd110_999_999, 34'd99_000_000, 34'd27_999_999, 34'd6_500_000_000,
      34'd4_444_444_444, 34'd37_000_000};
    foreach (edges[i]) send_freq(edges[i]);
    drain();
  endtask

  task automatic run_random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_freq(rand_freq());
    drain();
  endtask

  // register extremes; zero pfd stands for 1
  task automatic run_register_sweep;
    logic [29:0] pfds[6] = '{30'd0, 30'd1, 30'd1_000_000_000, 30'h3FFF_FFFF, 30'd61_440_000,
      30'd100_000_000};
    for (int i = 0; i < 6; i++) begin
      write_reg(fnpp_pkg::CFG_PFD, pfds[i]);
      write_reg(fnpp_pkg::CFG_MASH, 30'(i + 2));
      run_random_phase(12, 20, 20);
    end
  endtask

  initial begin
    fails = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    pfd_cur = 30'd100_000_000;
    order_cur = 3'd3;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = fnpp_pkg::CFG_PFD;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_edges();
    write_reg(fnpp_pkg::CFG_MASH, 30'd0);
    write_reg(fnpp_pkg::CFG_PFD, 30'd50_000_000);
    run_edges();
    run_random_phase(50, 0, 0);
    write_reg(fnpp_pkg::CFG_MASH, 30'd4);
    write_reg(fnpp_pkg::CFG_PFD, 30'd25_000_000);
    run_random_phase(50, 52, 0);
    write_reg(fnpp_pkg::CFG_MASH, 30'd1);
    write_reg(fnpp_pkg::CFG_PFD, 30'd10_000_000);
    run_random_phase(50, 0, 52);
    write_reg(fnpp_pkg::CFG_MASH, 30'd7);
    write_reg(fnpp_pkg::CFG_PFD, 30'd122_880_000);
    run_random_phase(50, 20, 20);
    run_register_sweep();
    repeat (2000) @(posedge clk);
    if (plans_pending.size() != 0) begin
      $error("%0d plans never came back", plans_pending.size());
      fails++;
    end
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
rtl/fnpp_pkg.sv
rtl/fnpp_div.sv
rtl/fractional_n_pll_frequency_planner.sv
verif/fractional_n_pll_frequency_planner_test.sv
